/* rtl/bal_pkg.sv */
// bal_pkg: shared types and codes for the bounded array list
// request and result payload structs, command and status codes
// no dependencies
package bal_pkg;

	localparam int VAL_W    = 32;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 4;
	localparam int FILL_W   = 5;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]        cmd;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [POS_W-1:0]    position;
		logic [FILL_W-1:0]   fill;
	} res_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SRCH  = 5'b00010,
		S_DEC   = 5'b00100,
		S_SHIFT = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

endpackage

/* rtl/bounded_array_list.sv */
// bounded_array_list: insertion-ordered list of up to CAPACITY signed values
// steps: search the held entries, decide, for a delete compact the entries after the hit,
// then hand over the result, which waits while the result register is stalled
// one request at a time; the next is accepted no earlier than the cycle after handover
// reset clears the count and control; entry ram contents are not cleared
// depends on bal_pkg, bal_ram, bal_ctrl
module bounded_array_list import bal_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int IW = $clog2(CAPACITY);

	logic             c_res_valid;
	logic             c_res_ready;
	res_t             c_res;
	logic             mem_we;
	logic [IW-1:0]    mem_waddr;
	logic [VAL_W-1:0] mem_wdata;
	logic             mem_re;
	logic [IW-1:0]    mem_raddr;
	logic [VAL_W-1:0] mem_rdata;
	logic             res_valid_q;
	res_t             res_q;

	bal_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.res_valid(c_res_valid),
		.res_ready(c_res_ready),
		.res      (c_res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	bal_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_entries (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// result register
	assign c_res_ready = !res_valid_q || !res_stall;
	assign res_valid   = res_valid_q;
	assign res         = res_q;

	always_ff @(posedge clk) begin
		if (c_res_valid && c_res_ready) begin
			res_q <= c_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (c_res_ready) begin
			res_valid_q <= c_res_valid;
		end
	end

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted while block not busy afterward");

	a_full_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.status == ST_FULL)) |-> (res.fill == FILL_W'(CAPACITY)))
		else $error("full status with list not at capacity");

	a_notfound: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.status == ST_NOTFOUND)) |-> (!res.found && (res.position == '0)))
		else $error("not found status with a match reported");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(c_res_valid && c_res_ready) |=> !c_res_valid)
		else $error("result handed over twice");

endmodule

/* rtl/bal_ram.sv */
// bal_ram: generic simple dual-port ram, one write and one read port
// read data registered
// no dependencies
module bal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/bal_ctrl.sv */
// bal_ctrl: sequencer for search, append and compaction over the entry ram
// holds the entry count; drives the ram ports
// depends on bal_pkg
module bal_ctrl import bal_pkg::*; #(
	parameter int CAPACITY = 16,
	localparam int IW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             res_valid,
	input  logic             res_ready,
	output res_t             res,
	output logic             mem_we,
	output logic [IW-1:0]    mem_waddr,
	output logic [VAL_W-1:0] mem_wdata,
	output logic             mem_re,
	output logic [IW-1:0]    mem_raddr,
	input  logic [VAL_W-1:0] mem_rdata
);

	state_t                state_q;
	logic [CMD_W-1:0]      cmd_q;
	logic [VAL_W-1:0]      val_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         nxt_cnt_q;
	logic [CW-1:0]         rd_idx_q;
	logic [CW-1:0]         cmp_idx_s1;
	logic                  cmp_vld_s1;
	logic                  hit_q;
	logic [IW-1:0]         pos_q;
	logic [STATUS_W-1:0]   status_q;
	logic                  issue;
	logic                  hit_now;
	logic                  walk_end;
	logic                  ins_ok;
	logic                  req_acc;

	assign req_acc   = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign issue     = ((state_q == S_SRCH) || (state_q == S_SHIFT)) && (rd_idx_q < cnt_q);
	assign hit_now   = (state_q == S_SRCH) && cmp_vld_s1 && (mem_rdata == val_q);
	assign walk_end  = !cmp_vld_s1 && !issue;
	assign ins_ok    = (cmd_q == CMD_INSERT) && (cnt_q < CW'(CAPACITY));

	// ram access
	assign mem_re    = issue;
	assign mem_raddr = rd_idx_q[IW-1:0];
	assign mem_we    = ((state_q == S_SHIFT) && cmp_vld_s1) || ((state_q == S_DEC) && ins_ok);
	assign mem_waddr = (state_q == S_SHIFT) ? IW'(cmp_idx_s1 - CW'(1)) : cnt_q[IW-1:0];
	assign mem_wdata = (state_q == S_SHIFT) ? mem_rdata : val_q;

	assign res_valid    = (state_q == S_FIN);
	assign res.status   = status_q;
	assign res.found    = hit_q;
	assign res.position = POS_W'(pos_q);
	assign res.fill     = FILL_W'(nxt_cnt_q);

	always_ff @(posedge clk) begin
		if (req_acc) begin
			cmd_q <= req.cmd;
			val_q <= req.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			nxt_cnt_q  <= '0;
			rd_idx_q   <= '0;
			cmp_idx_s1 <= '0;
			cmp_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
			pos_q      <= '0;
			status_q   <= ST_DONE;
		end else begin
			cmp_vld_s1 <= issue;
			cmp_idx_s1 <= rd_idx_q;
			if (issue) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						rd_idx_q <= '0;
						hit_q    <= 1'b0;
						pos_q    <= '0;
						state_q  <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (hit_now) begin
						hit_q   <= 1'b1;
						pos_q   <= cmp_idx_s1[IW-1:0];
						state_q <= S_DEC;
					end else if (walk_end) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (cmd_q == CMD_INSERT) begin
						status_q  <= ins_ok ? ST_DONE : ST_FULL;
						nxt_cnt_q <= ins_ok ? cnt_q + CW'(1) : cnt_q;
						state_q   <= S_FIN;
					end else if ((cmd_q == CMD_DELETE) && hit_q) begin
						status_q  <= ST_DONE;
						nxt_cnt_q <= cnt_q - CW'(1);
						rd_idx_q  <= CW'(pos_q) + CW'(1);
						state_q   <= S_SHIFT;
					end else begin
						status_q  <= hit_q ? ST_DONE : ST_NOTFOUND;
						nxt_cnt_q <= cnt_q;
						state_q   <= S_FIN;
					end
				end
				S_SHIFT: begin
					if (walk_end) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (res_ready) begin
						cnt_q   <= nxt_cnt_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* tb/sv/bounded_array_list_tb.sv */
// bounded_array_list_tb: self-checking bench for the bounded array list
// predicts every result from its own copy of the list and compares field by field
// depends on bal_pkg and bounded_array_list
module bounded_array_list_tb;
	import bal_pkg::*;

	localparam int CAP = 16;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
	localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	logic [VAL_W-1:0] held_vals [CAP];
	int held_count = 0;
	res_t res_due [$];
	res_t res_want;

	int fail_cnt = 0;
	int burst_left = 0;
	int stall_cyc = 0;
	int n_cmd [4] = '{0, 0, 0, 0};
	int n_full_reject = 0;
	int n_miss = 0;
	int n_at_cap = 0;
	int n_at_empty = 0;
	int n_checked = 0;

	bounded_array_list #(.CAPACITY(CAP)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #5 clk = ~clk;

	// applies one request to the local list and returns the result it should give
	function automatic res_t list_apply(req_t r);
		res_t o;
		logic hit;
		int hit_at;
		int i;
		hit = 1'b0;
		hit_at = 0;
		for (i = 0; i < held_count; i++) begin
			if (!hit && held_vals[i] == r.value) begin
				hit = 1'b1;
				hit_at = i;
			end
		end
		o.found = hit;
		o.position = hit_at[POS_W-1:0];
		case (r.cmd)
			CMD_INSERT: begin
				if (held_count < CAP) begin
					held_vals[held_count] = r.value;
					held_count++;
					o.status = ST_DONE;
				end else begin
					o.status = ST_FULL;
				end
			end
			CMD_DELETE: begin
				if (hit) begin
					for (i = hit_at; i + 1 < held_count; i++)
						held_vals[i] = held_vals[i + 1];
					held_count--;
					o.status = ST_DONE;
				end else begin
					o.status = ST_NOTFOUND;
				end
			end
			default: begin
				o.status = hit ? ST_DONE : ST_NOTFOUND;
			end
		endcase
		o.fill = held_count[FILL_W-1:0];
		n_cmd[r.cmd]++;
		if (o.status == ST_FULL)
			n_full_reject++;
		if (o.status == ST_NOTFOUND)
			n_miss++;
		if (held_count == CAP)
			n_at_cap++;
		if (held_count == 0)
			n_at_empty++;
		return o;
	endfunction

	task automatic send_req(input logic [CMD_W-1:0] c, input logic [VAL_W-1:0] v);
		req_t r;
		r.cmd = c;
		r.value = v;
		req_valid <= 1'b1;
		req <= r;
		do
			@(negedge clk);
		while (req_stall);
		@(posedge clk);
		res_due.push_back(list_apply(r));
	endtask

	// sender bursts with random gaps between them
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			case ($urandom_range(0, 5))
				0, 1: gap = 0;
				2, 3, 4: gap = $urandom_range(1, 12);
				default: gap = $urandom_range(13, 40);
			endcase
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_paced(input logic [CMD_W-1:0] c, input logic [VAL_W-1:0] v);
		send_req(c, v);
		pace();
	endtask

	task automatic test_empty_list();
		send_paced(CMD_QUERY, 32'h0);
		send_paced(CMD_DELETE, VAL_MAX);
		send_paced(CMD_UNUSED, 32'hFFFF_FFFF);
	endtask

	task automatic test_fill_and_full();
		int i;
		send_paced(CMD_INSERT, VAL_MIN);
		send_paced(CMD_INSERT, VAL_MAX);
		send_paced(CMD_INSERT, 32'h0);
		send_paced(CMD_INSERT, 32'hFFFF_FFFF);
		send_paced(CMD_INSERT, 32'h5555_5555);
		send_paced(CMD_INSERT, 32'hAAAA_AAAA);
		send_paced(CMD_INSERT, VAL_MIN);
		for (i = 0; i < CAP - 7; i++)
			send_paced(CMD_INSERT, 32'h1000_0000 + i);
		send_paced(CMD_INSERT, 32'd42);
		send_paced(CMD_INSERT, VAL_MAX);
		send_paced(CMD_QUERY, 32'h1000_0000 + CAP - 8);
	endtask

	task automatic test_delete_shift();
		send_paced(CMD_DELETE, VAL_MIN);
		send_paced(CMD_DELETE, VAL_MIN);
		send_paced(CMD_DELETE, 32'h1000_0000 + CAP - 8);
		send_paced(CMD_DELETE, 32'd42);
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		logic [VAL_W-1:0] v;
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5 && held_count > 0) begin
			v = held_vals[$urandom_range(0, held_count - 1)];
		end else if (sel < 8) begin
			case ($urandom_range(0, 7))
				0: v = VAL_MIN;
				1: v = VAL_MAX;
				2: v = 32'h0;
				3: v = 32'hFFFF_FFFF;
				4: v = 32'h1;
				default: v = $urandom_range(2, 5);
			endcase
		end else begin
			v = $urandom;
		end
		return v;
	endfunction

	task automatic test_random_traffic(input int n);
		int k;
		int roll;
		int trend_left;
		logic growing;
		logic [CMD_W-1:0] c;
		growing = 1'b0;
		trend_left = 0;
		for (k = 0; k < n; k++) begin
			if (trend_left == 0) begin
				growing = ~growing;
				trend_left = $urandom_range(20, 80);
			end
			trend_left--;
			roll = $urandom_range(0, 99);
			if (roll < (growing ? 55 : 20))
				c = CMD_INSERT;
			else if (roll < (growing ? 75 : 70))
				c = CMD_DELETE;
			else if (roll < 95)
				c = CMD_QUERY;
			else
				c = CMD_UNUSED;
			send_paced(c, pick_value());
		end
	endtask

	task automatic report(input string fname, input int want, input int got);
		fail_cnt++;
		if (fail_cnt <= 30)
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
	endtask

	// receiver stall pattern: none, sparse random, dense random, then periodic, in turn
	always @(posedge clk) begin
		stall_cyc <= stall_cyc + 1;
		case (stall_cyc[9:8])
			2'd0: res_stall <= 1'b0;
			2'd1: res_stall <= ($urandom_range(0, 3) == 0);
			2'd2: res_stall <= ($urandom_range(0, 3) != 0);
			default: res_stall <= (stall_cyc[5:3] >= 3'd5);
		endcase
	end

	// outputs are stable from negedge to the next accepting edge
	always @(negedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (res_due.size() == 0) begin
				fail_cnt++;
				$display("%0t: result with none expected, actual status %0d fill %0d",
					$time, res.status, res.fill);
			end else begin
				res_want = res_due.pop_front();
				n_checked++;
				if (res.status !== res_want.status)
					report("status", res_want.status, res.status);
				if (res.found !== res_want.found)
					report("found", res_want.found, res.found);
				if (res.position !== res_want.position)
					report("position", res_want.position, res.position);
				if (res.fill !== res_want.fill)
					report("fill", res_want.fill, res.fill);
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_fill_and_full();
		test_delete_shift();
		test_random_traffic(1900);
		req_valid <= 1'b0;
		while (res_due.size() != 0)
			@(posedge clk);
		repeat (2 * CAP + 20) @(posedge clk);
		$display("%0d requests: %0d insert, %0d delete, %0d query, %0d unused code",
			n_cmd[0] + n_cmd[1] + n_cmd[2] + n_cmd[3],
			n_cmd[0], n_cmd[1], n_cmd[2], n_cmd[3]);
		$display("%0d results checked; full %0d times, empty %0d times, %0d rejects, %0d misses",
			n_checked, n_at_cap, n_at_empty, n_full_reject, n_miss);
		if (fail_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout with %0d results outstanding", res_due.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
